>>> rtl/nsptp_pkg.sv
`timescale 1ns / 1ps

package nsptp_pkg;

   // Width of the shared multiply-add result: covers (y*w + x)*d + k for sides up to 255.
   localparam int CALC_W = 18;

   localparam int DEFAULT_MAX_SIDE     = 128;
   localparam int DEFAULT_MAX_CHANNELS = 4;

   // Register indexes on the configuration port (byte address = 4 * index).
   localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_CHANNELS      = 2'd2;

   // Request kinds.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [6:0] column;
      logic [6:0] row;
      logic [1:0] channel_index;
      logic [7:0] write_byte;
   } nsptp_req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [7:0] scaled_width;
      logic [7:0] scaled_height;
      logic       out_of_range;
   } nsptp_rsp_type;

   // Smallest lg with 2**lg >= n, for n in 1..255.
   function automatic logic [3:0] ceil_log2_side(input logic [7:0] n);
      logic [3:0] lg;
      lg = 4'd8;
      for (int i = 8; i >= 0; i--) begin
         if ((9'd1 << i) >= {1'b0, n}) begin
            lg = 4'(i);
         end
      end
      return lg;
   endfunction

endpackage

>>> rtl/nearest_scale_to_power_of_two.sv
`timescale 1ns / 1ps

// Nearest-neighbor scaler of a stored source image up to power-of-two sides.
//
// Input channel: req_data is taken at a rising edge with start high and busy low.
//   A write word stores one channel byte at a source (column, row); a read word
//   fetches one channel byte of the scaled image at a destination (column, row).
// Result channel: every accepted word gives exactly one result on rsp_data, held
//   for one cycle and marked by rsp_valid. The receiver cannot stall; a result is
//   gone after its cycle.
// Handshake: for a read or a write, busy stays high until the edge that raises
//   rsp_valid, so a new word can be taken in the cycle the result is shown.
//   A read makes four passes through the one shared multiply-add unit
//   (scaled column, scaled row, row base, byte address), a separate step at
//   the shared shift-and-clamp for the row, and a step at the byte store port.
// Configuration: APB-style port, registers at byte addresses 0 (source width),
//   4 (source height) and 8 (channels). Write only while the block is idle.
// Reset (synchronous, active high) returns the registers to width 1, height 1,
//   three channels and drops any word in flight. The byte store is not cleared:
//   read only entries that were written.
module nearest_scale_to_power_of_two
   import nsptp_pkg::*;
#(
   parameter int MAX_SIDE     = DEFAULT_MAX_SIDE,
   parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          start,
   output logic          busy,
   input  nsptp_req_type req_data,
   // result channel
   output logic          rsp_valid,
   output nsptp_rsp_type rsp_data,
   // configuration port
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [3:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE * MAX_CHANNELS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   // Width registers are 8 bits; clamp to the smaller of 255 and MAX_SIDE.
   localparam int SIDE_CAP    = (MAX_SIDE > 255) ? 255 : MAX_SIDE;
   localparam logic [7:0] SIDE_CAP_B = 8'(SIDE_CAP);
   localparam logic [2:0] CH_CAP_B   = 3'(MAX_CHANNELS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MULX,
      S_MULY,
      S_YCLAMP,
      S_ROW,
      S_CHAN,
      S_MEM
   } state_type;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [7:0] src_width_ff;
   logic [7:0] src_height_ff;
   logic [2:0] channels_ff;
   logic       cfg_write;

   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 8'd1;
         src_height_ff <= 8'd1;
         channels_ff   <= 3'd3;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_SOURCE_WIDTH:  src_width_ff  <= pwdata[7:0];
            REG_SOURCE_HEIGHT: src_height_ff <= pwdata[7:0];
            REG_CHANNELS:      channels_ff   <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SOURCE_WIDTH:  prdata = {24'd0, src_width_ff};
         REG_SOURCE_HEIGHT: prdata = {24'd0, src_height_ff};
         REG_CHANNELS:      prdata = {29'd0, channels_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // Effective geometry: clamp the registers into their legal ranges.
   logic [7:0] w_eff;
   logic [7:0] h_eff;
   logic [2:0] d_eff;
   logic [3:0] lg_w;
   logic [3:0] lg_h;
   logic [8:0] scaled_w;
   logic [8:0] scaled_h;

   assign w_eff = (src_width_ff == 8'd0) ? 8'd1 :
                  ((src_width_ff > SIDE_CAP_B) ? SIDE_CAP_B : src_width_ff);
   assign h_eff = (src_height_ff == 8'd0) ? 8'd1 :
                  ((src_height_ff > SIDE_CAP_B) ? SIDE_CAP_B : src_height_ff);
   assign d_eff = (channels_ff == 3'd0) ? 3'd1 :
                  ((channels_ff > CH_CAP_B) ? CH_CAP_B : channels_ff);
   assign lg_w     = ceil_log2_side(w_eff);
   assign lg_h     = ceil_log2_side(h_eff);
   assign scaled_w = 9'd1 << lg_w;
   assign scaled_h = 9'd1 << lg_h;

   // ---------------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------------
   state_type        state_ff,     state_in;
   nsptp_req_type    req_ff,       req_in;
   logic [7:0]       x_ff,         x_in;
   logic [7:0]       y_ff,         y_in;
   logic [CALC_W-1:0] p_ff,        p_in;
   logic             oor_ff,       oor_in;
   logic             rd_ff,        rd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       sw_ff,        sw_in;
   logic [7:0]       sh_ff,        sh_in;
   logic [7:0]       mem_q_ff;

   // Shared multiply-add unit: p = a * b + c.
   logic [15:0]       mac_a;
   logic [7:0]        mac_b;
   logic [7:0]        mac_c;
   logic [23:0]       mac_prod;
   logic [CALC_W-1:0] mac_out;

   assign mac_prod = {8'd0, mac_a} * {16'd0, mac_b};
   assign mac_out  = mac_prod[CALC_W-1:0] + CALC_W'(mac_c);

   // Shared shift-and-clamp: source coordinate = p >> (lg + 1), held below the side.
   logic [3:0]  shift_lg;
   logic [7:0]  shift_lim;
   logic [15:0] shift_val;
   logic [7:0]  shift_coord;

   assign shift_lg    = (state_ff == S_MULY) ? lg_w : lg_h;
   assign shift_lim   = (state_ff == S_MULY) ? w_eff : h_eff;
   assign shift_val   = p_ff[15:0] >> ({1'b0, shift_lg} + 5'd1);
   assign shift_coord = (shift_val >= {8'd0, shift_lim}) ? (shift_lim - 8'd1) : shift_val[7:0];

   // Range check of an incoming word against the current geometry.
   logic accept;
   logic req_oor;

   assign accept = start && !busy;

   always_comb begin
      if (req_data.req_type == REQ_WRITE) begin
         req_oor = ({1'b0, req_data.column} >= w_eff) ||
                   ({1'b0, req_data.row} >= h_eff) ||
                   ({1'b0, req_data.channel_index} >= d_eff);
      end else begin
         req_oor = ({2'b0, req_data.column} >= scaled_w) ||
                   ({2'b0, req_data.row} >= scaled_h) ||
                   ({1'b0, req_data.channel_index} >= d_eff);
      end
   end

   // Operand selection for the shared unit.
   always_comb begin
      mac_a = 16'd0;
      mac_b = 8'd0;
      mac_c = 8'd0;
      case (state_ff)
         S_MULX: begin
            mac_a = {8'd0, req_ff.column, 1'b1};
            mac_b = w_eff;
         end
         S_MULY: begin
            mac_a = {8'd0, req_ff.row, 1'b1};
            mac_b = h_eff;
         end
         S_ROW: begin
            mac_a = {8'd0, y_ff};
            mac_b = w_eff;
            mac_c = x_ff;
         end
         S_CHAN: begin
            mac_a = p_ff[15:0];
            mac_b = {5'd0, d_eff};
            mac_c = {6'd0, req_ff.channel_index};
         end
         default: ;
      endcase
   end

   // Next-state and next-value logic.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      p_in         = p_ff;
      oor_in       = oor_ff;
      rd_in        = rd_ff;
      rsp_valid_in = 1'b0;
      sw_in        = sw_ff;
      sh_in        = sh_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               sw_in  = scaled_w[7:0];
               sh_in  = scaled_h[7:0];
               oor_in = req_oor;
               x_in   = {1'b0, req_data.column};
               y_in   = {1'b0, req_data.row};
               if (req_oor) begin
                  // answer at once, no store access
                  rd_in        = 1'b0;
                  rsp_valid_in = 1'b1;
               end else if (req_data.req_type == REQ_READ) begin
                  state_in = S_MULX;
               end else begin
                  state_in = S_ROW;
               end
            end
         end
         S_MULX: begin
            p_in     = mac_out;
            state_in = S_MULY;
         end
         S_MULY: begin
            x_in     = shift_coord;
            p_in     = mac_out;
            state_in = S_YCLAMP;
         end
         S_YCLAMP: begin
            y_in     = shift_coord;
            state_in = S_ROW;
         end
         S_ROW: begin
            p_in     = mac_out;
            state_in = S_CHAN;
         end
         S_CHAN: begin
            p_in     = mac_out;
            state_in = S_MEM;
         end
         S_MEM: begin
            rd_in        = (req_ff.req_type == REQ_READ);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         oor_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
         oor_ff       <= oor_in;
      end
      req_ff <= req_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      p_ff   <= p_in;
      sw_ff  <= sw_in;
      sh_ff  <= sh_in;
   end

   // ---------------------------------------------------------------------------
   // Source byte store: one port, registered read
   // ---------------------------------------------------------------------------
   logic [7:0]        store_mem [STORE_DEPTH];
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic              mem_re;

   assign mem_addr = ADDR_W'(p_ff);
   assign mem_we   = (state_ff == S_MEM) && (req_ff.req_type == REQ_WRITE);
   assign mem_re   = (state_ff == S_MEM) && (req_ff.req_type == REQ_READ);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= req_ff.write_byte;
      end
      if (mem_re) begin
         mem_q_ff <= store_mem[mem_addr];
      end
   end

   // ---------------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------------
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.read_byte     = rd_ff ? mem_q_ff : 8'd0;
      rsp_data.scaled_width  = sw_ff;
      rsp_data.scaled_height = sh_ff;
      rsp_data.out_of_range  = oor_ff;
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a word is still in work");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither in work nor answered");

   a_oor_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.read_byte == 8'd0))
      else $error("out-of-range result carries data");

   a_column_in_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW) |-> (x_ff < w_eff))
      else $error("source column beyond width");

   a_addr_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MEM) |-> (32'(p_ff) < 32'(STORE_DEPTH)))
      else $error("store address beyond depth");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import nsptp_pkg::*;

   localparam int STORE_DEPTH = 128 * 128 * 4;
   localparam int CYCLE_LIMIT = 400000;

   // Keep a private copy of the source image and the registers, and
   // queue the result word that each accepted request word should give.
   class scaler_scoreboard;
      logic [7:0]    image_bytes [STORE_DEPTH];
      bit            loaded [STORE_DEPTH];
      logic [7:0]    width_reg;
      logic [7:0]    height_reg;
      logic [2:0]    chan_reg;
      int            eff_w, eff_h, eff_d;
      int            scaled_w, scaled_h, lg_w, lg_h;
      nsptp_rsp_type expected_q [$];
      int            failures;

      function new();
         width_reg = 8'd1;
         height_reg = 8'd1;
         failures = 0;
         set_register(REG_CHANNELS, 32'd3);
      endfunction

      // Store the register as written; clamp only the sides and depth in use.
      function void set_register(input logic [1:0] idx, input logic [31:0] value);
         case (idx)
            REG_SOURCE_WIDTH: width_reg = value[7:0];
            REG_SOURCE_HEIGHT: height_reg = value[7:0];
            REG_CHANNELS: chan_reg = value[2:0];
            default: ;
         endcase
         eff_w = (width_reg == 0) ? 1 : (width_reg > 128) ? 128 : int'(width_reg);
         eff_h = (height_reg == 0) ? 1 : (height_reg > 128) ? 128 : int'(height_reg);
         eff_d = (chan_reg == 0) ? 1 : (chan_reg > 4) ? 4 : int'(chan_reg);
         scaled_w = 1;
         lg_w = 0;
         while (scaled_w < eff_w) begin
            scaled_w = scaled_w * 2;
            lg_w++;
         end
         scaled_h = 1;
         lg_h = 0;
         while (scaled_h < eff_h) begin
            scaled_h = scaled_h * 2;
            lg_h++;
         end
      endfunction

      // Sample from the pixel center of the scaled grid.
      function void to_source(input int col, input int row, output int sx, output int sy);
         sx = ((2 * col + 1) * eff_w) >> (lg_w + 1);
         sy = ((2 * row + 1) * eff_h) >> (lg_h + 1);
         if (sx >= eff_w) sx = eff_w - 1;
         if (sy >= eff_h) sy = eff_h - 1;
      endfunction

      // Byte address a read fetches, or -1 for anything but an in-range read.
      function int source_address(input nsptp_req_type wd);
         int sx, sy;
         if (wd.req_type != REQ_READ || wd.column >= scaled_w || wd.row >= scaled_h
             || wd.channel_index >= eff_d) return -1;
         to_source(wd.column, wd.row, sx, sy);
         return (sy * eff_w + sx) * eff_d + wd.channel_index;
      endfunction

      // Build a write word that loads the byte a read would fetch, if that byte
      // was never loaded.
      function bit missing_source_write(input nsptp_req_type wd, output nsptp_req_type ld);
         int a, sx, sy;
         logic [31:0] value;
         ld = '0;
         a = source_address(wd);
         if (a < 0 || loaded[a]) return 1'b0;
         to_source(wd.column, wd.row, sx, sy);
         value = $urandom;
         ld.req_type = REQ_WRITE;
         ld.column = 7'(sx);
         ld.row = 7'(sy);
         ld.channel_index = wd.channel_index;
         ld.write_byte = value[7:0];
         return 1'b1;
      endfunction

      function void note_input(input nsptp_req_type wd);
         nsptp_rsp_type e;
         int a;
         e.read_byte = 8'd0;
         e.scaled_width = 8'(scaled_w);
         e.scaled_height = 8'(scaled_h);
         e.out_of_range = 1'b0;
         if (wd.req_type == REQ_WRITE) begin
            if (wd.column >= eff_w || wd.row >= eff_h || wd.channel_index >= eff_d) begin
               e.out_of_range = 1'b1;
            end else begin
               a = (wd.row * eff_w + wd.column) * eff_d + wd.channel_index;
               image_bytes[a] = wd.write_byte;
               loaded[a] = 1'b1;
            end
         end else begin
            a = source_address(wd);
            if (a < 0) e.out_of_range = 1'b1;
            else e.read_byte = image_bytes[a];
         end
         expected_q.push_back(e);
      endfunction

      function void check_result(input nsptp_rsp_type got);
         nsptp_rsp_type e;
         if (expected_q.size() == 0) begin
            $error("result word %h with no request pending", got);
            failures++;
            return;
         end
         e = expected_q.pop_front();
         if (got.read_byte !== e.read_byte) begin
            $error("read_byte: expected %0d, actual %0d", e.read_byte, got.read_byte);
            failures++;
         end
         if (got.scaled_width !== e.scaled_width) begin
            $error("scaled_width: expected %0d, actual %0d", e.scaled_width, got.scaled_width);
            failures++;
         end
         if (got.scaled_height !== e.scaled_height) begin
            $error("scaled_height: expected %0d, actual %0d", e.scaled_height,
                   got.scaled_height);
            failures++;
         end
         if (got.out_of_range !== e.out_of_range) begin
            $error("out_of_range: expected %0d, actual %0d", e.out_of_range, got.out_of_range);
            failures++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   nsptp_req_type req_data;
   logic          rsp_valid;
   nsptp_rsp_type rsp_data;
   logic          psel;
   logic          penable;
   logic          pwrite;
   logic [3:0]    paddr;
   logic [31:0]   pwdata;
   logic [31:0]   prdata;
   logic          pready;

   scaler_scoreboard sb;
   int burst_left;
   int words_sent;
   int cycle_count;

   nearest_scale_to_power_of_two DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run; a stuck handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Take each result word at the edge that ends its strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   function automatic nsptp_req_type make_word(input logic kind, input int col, input int row,
                                                input int ch, input int byte_val);
      nsptp_req_type wd;
      wd.req_type = kind;
      wd.column = 7'(col);
      wd.row = 7'(row);
      wd.channel_index = 2'(ch);
      wd.write_byte = 8'(byte_val);
      return wd;
   endfunction

   // Present one request word and hold it until the block takes it. Drop start
   // for a random gap at the end of each burst; keep it high inside a burst.
   task automatic send_word(input nsptp_req_type wd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_data <= wd;
      do begin
         @(posedge clock);
      end while (busy);
      sb.note_input(wd);
      words_sent++;
   endtask

   // Load the byte an in-range read would fetch first, so no read ever
   // touches an entry that was never written.
   task automatic issue_word(input nsptp_req_type wd);
      nsptp_req_type ld;
      if (sb.missing_source_write(wd, ld)) send_word(ld);
      send_word(wd);
   endtask

   // Drop start, wait out every pending result, then let the pipeline drain.
   task automatic settle();
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      burst_left = 0;
   endtask

   // Write one register in a setup and an access phase, then read it back.
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] kept;
      kept = (idx == REG_CHANNELS) ? (value & 32'h7) : (value & 32'hFF);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      sb.set_register(idx, value);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      if (prdata !== kept) begin
         $error("prdata: expected %0d, actual %0d", kept, prdata);
         sb.failures++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h, input int d);
      settle();
      write_register(REG_SOURCE_WIDTH, 32'(w));
      write_register(REG_SOURCE_HEIGHT, 32'(h));
      write_register(REG_CHANNELS, 32'(d));
   endtask

   // Mostly well-formed words inside the image, some noise over the full fields.
   task automatic random_words(input int count);
      int target, pick;
      logic [31:0] noise;
      nsptp_req_type wd;
      target = words_sent + count;
      while (words_sent < target) begin
         pick = $urandom_range(0, 99);
         noise = $urandom;
         if (pick < 40) begin
            wd = make_word(REQ_WRITE, $urandom_range(0, sb.eff_w - 1),
                           $urandom_range(0, sb.eff_h - 1), $urandom_range(0, sb.eff_d - 1),
                           noise[7:0]);
         end else if (pick < 85) begin
            wd = make_word(REQ_READ, $urandom_range(0, sb.scaled_w - 1),
                           $urandom_range(0, sb.scaled_h - 1), $urandom_range(0, sb.eff_d - 1),
                           noise[7:0]);
         end else begin
            wd = noise[24:0];
         end
         issue_word(wd);
      end
   endtask

   function automatic int random_side();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 12);
   endfunction

   initial begin
      sb = new();
      burst_left = 0;
      words_sent = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry: one pixel of three bytes, every other coordinate
      // and the fourth channel fall outside.
      issue_word(make_word(REQ_WRITE, 0, 0, 0, 8'h00));
      issue_word(make_word(REQ_WRITE, 0, 0, 1, 8'hFF));
      issue_word(make_word(REQ_WRITE, 0, 0, 2, 8'hA5));
      issue_word(make_word(REQ_WRITE, 1, 0, 0, 8'h11));
      issue_word(make_word(REQ_WRITE, 0, 1, 0, 8'h22));
      issue_word(make_word(REQ_WRITE, 0, 0, 3, 8'h33));
      issue_word(make_word(REQ_WRITE, 127, 127, 3, 8'hFF));
      issue_word(make_word(REQ_READ, 0, 0, 0, 8'h00));
      issue_word(make_word(REQ_READ, 0, 0, 1, 8'hFF));
      issue_word(make_word(REQ_READ, 0, 0, 2, 8'h00));
      issue_word(make_word(REQ_READ, 1, 0, 0, 8'h00));
      issue_word(make_word(REQ_READ, 0, 0, 3, 8'h00));
      issue_word(make_word(REQ_READ, 127, 127, 3, 8'hFF));
      random_words(90);

      // Largest image: a power-of-two side maps to itself, far corner included.
      set_geometry(128, 128, 4);
      issue_word(make_word(REQ_WRITE, 127, 127, 3, 8'hFF));
      issue_word(make_word(REQ_WRITE, 0, 0, 0, 8'h00));
      issue_word(make_word(REQ_READ, 127, 127, 3, 8'h00));
      issue_word(make_word(REQ_READ, 0, 0, 0, 8'hFF));
      issue_word(make_word(REQ_READ, 64, 0, 3, 8'h00));
      random_words(90);

      // Fixed shapes: odd sides, registers below and above range, thin strips.
      set_geometry(5, 3, 3);
      random_words(90);
      set_geometry(0, 0, 0);
      random_words(90);
      set_geometry(255, 255, 7);
      random_words(90);
      set_geometry(128, 1, 1);
      random_words(90);
      set_geometry(1, 128, 2);
      random_words(90);
      set_geometry(3, 5, 4);
      random_words(90);
      set_geometry(100, 7, 2);
      random_words(90);
      set_geometry(65, 2, 5);
      random_words(90);

      // Random shapes, mostly small, with earlier image bytes left in place.
      repeat (6) begin
         set_geometry(random_side(), random_side(), $urandom_range(0, 7));
         random_words(90);
      end

      start <= 1'b0;
      for (int i = 0; i < 2000 && sb.expected_q.size() != 0; i++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $error("%0d result words never arrived", sb.expected_q.size());
         sb.failures += sb.expected_q.size();
      end
      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
